@@ hw/rtl/filtered_fifo_mailbox_defines.svh @@
// Assertion macros for the filtered FIFO mailbox.
`ifndef FILTERED_FIFO_MAILBOX_DEFINES_SVH
`define FILTERED_FIFO_MAILBOX_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FFM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mailbox check failed");

// Next-cycle implication checked outside reset.
`define FFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mailbox check failed");

`endif

@@ hw/rtl/ffm_pkg.sv @@
// Shared types and constants of the filtered FIFO mailbox.
package ffm_pkg;

    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_RECEIVE = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;
    localparam logic [1:0] CMD_FLUSH   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_TOOBIG  = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    localparam logic [15:0] MAX_SIZE_RESET = 16'd4096;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] sender_tid;
        logic [31:0] sender_generation;
        logic [31:0] message_type;
        logic [31:0] message_id;
        logic [31:0] payload_handle;
        logic [15:0] payload_size;
        logic        filter_any;
        logic [31:0] filter_sender;
        logic [15:0] buffer_capacity;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] got_sender_tid;
        logic [31:0] got_generation;
        logic [31:0] got_type;
        logic [31:0] got_id;
        logic [15:0] got_size;
        logic [31:0] got_payload_handle;
        logic [4:0]  pending_count;
    } rsp_t;

    // One stored message, held in the slot memory.
    typedef struct packed {
        logic [31:0] sender;
        logic [31:0] generation;
        logic [31:0] mtype;
        logic [31:0] ident;
        logic [15:0] size;
        logic [31:0] payload;
        logic [31:0] order;
    } slot_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic finish;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

@@ hw/rtl/ffm_if.sv @@
// Valid/ready channel interface carrying one mailbox transaction.
interface ffm_req_if
    import ffm_pkg::*;
();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ffm_rsp_if
    import ffm_pkg::*;
();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/ffm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module ffm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/ffm_ctrl.sv @@
// Controller state machine of the mailbox: accept, scan, finish, respond.
module ffm_ctrl
    import ffm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output ctl_t ctl,
    input  sts_t sts
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PRIME = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctl            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                ctl.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                ctl.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

@@ hw/rtl/ffm_datapath.sv @@
// Datapath of the mailbox: slot memory, valid bits, slot scan and result register.
module ffm_datapath
    import ffm_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  logic [15:0] max_message_size,
    input  ctl_t        ctl,
    output sts_t        sts,
    output rsp_t        rsp,
    output logic [SLOT_COUNT-1:0] valid_bits
);
    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);

    req_t            req_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [31:0]     order_reg;
    logic [CW-1:0]   held_reg;
    logic [IW-1:0]   rd_idx_reg;
    logic [IW-1:0]   cur_idx_reg;
    logic            cur_live_reg;
    logic            found_reg;
    logic [IW-1:0]   best_idx_reg;
    slot_t           best_reg;
    logic            free_found_reg;
    logic [IW-1:0]   free_idx_reg;
    rsp_t            rsp_reg;
    rsp_t            rsp_next;
    slot_t           rdata;
    slot_t           wdata;
    logic            we;
    logic            match;
    logic            send_ok;

    assign sts.scan_last = (cur_idx_reg == IW'(SLOT_COUNT - 1));
    assign valid_bits    = valid_reg;
    assign rsp           = rsp_reg;

    assign send_ok = (req_reg.payload_size <= max_message_size)
                  && !(req_reg.payload_size != 16'd0 && req_reg.payload_handle == 32'd0);

    always_comb
    begin
        wdata.sender     = req_reg.sender_tid;
        wdata.generation = req_reg.sender_generation;
        wdata.mtype      = req_reg.message_type;
        wdata.ident      = req_reg.message_id;
        wdata.size       = req_reg.payload_size;
        wdata.payload    = req_reg.payload_handle;
        wdata.order      = order_reg;
    end

    assign we = ctl.finish && (req_reg.cmd == CMD_SEND) && send_ok && free_found_reg;

    ffm_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (free_idx_reg),
        .wdata (wdata),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    assign match = cur_live_reg && valid_reg[cur_idx_reg]
                && (req_reg.filter_any || rdata.sender == req_reg.filter_sender);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= req;
        end
        if (ctl.scan_start)
        begin
            rd_idx_reg <= rd_idx_reg + IW'(1);
        end
        else if (ctl.scan_step)
        begin
            rd_idx_reg <= rd_idx_reg + IW'(1);
        end
        else
        begin
            rd_idx_reg <= '0;
        end
        if (ctl.scan_start)
        begin
            cur_idx_reg <= '0;
        end
        else if (ctl.scan_step)
        begin
            cur_idx_reg <= cur_idx_reg + IW'(1);
        end
        if (ctl.scan_step && match && (!found_reg || rdata.order < best_reg.order))
        begin
            best_reg     <= rdata;
            best_idx_reg <= cur_idx_reg;
        end
        if (ctl.scan_step && !valid_reg[cur_idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= cur_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_live_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctl.scan_start)
        begin
            cur_live_reg   <= 1'b1;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (ctl.scan_step)
        begin
            if (match)
            begin
                found_reg <= 1'b1;
            end
            if (!valid_reg[cur_idx_reg])
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            order_reg <= '0;
            held_reg  <= '0;
        end
        else if (ctl.finish)
        begin
            case (req_reg.cmd)
                CMD_SEND:
                begin
                    if (we)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        order_reg <= order_reg + 32'd1;
                        held_reg  <= held_reg + CW'(1);
                    end
                end
                CMD_RECEIVE:
                begin
                    if (found_reg && best_reg.size <= req_reg.buffer_capacity)
                    begin
                        valid_reg[best_idx_reg] <= 1'b0;
                        held_reg <= held_reg - CW'(1);
                    end
                end
                CMD_FLUSH:
                begin
                    valid_reg <= '0;
                    order_reg <= '0;
                    held_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_next = '0;
        rsp_next.pending_count = 5'(held_reg);
        case (req_reg.cmd)
            CMD_SEND:
            begin
                if (req_reg.payload_size > max_message_size)
                begin
                    rsp_next.status = ST_TOOBIG;
                end
                else if (!send_ok)
                begin
                    rsp_next.status = ST_INVALID;
                end
                else if (!free_found_reg)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    rsp_next.pending_count = 5'(held_reg + CW'(1));
                end
            end
            CMD_FLUSH:
            begin
                rsp_next.pending_count = 5'd0;
            end
            default:
            begin
                if (!found_reg)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.got_sender_tid = best_reg.sender;
                    rsp_next.got_generation = best_reg.generation;
                    rsp_next.got_type       = best_reg.mtype;
                    rsp_next.got_id         = best_reg.ident;
                    rsp_next.got_size       = best_reg.size;
                    if (req_reg.cmd == CMD_RECEIVE)
                    begin
                        if (best_reg.size > req_reg.buffer_capacity)
                        begin
                            rsp_next.status = ST_TOOBIG;
                        end
                        else
                        begin
                            rsp_next.got_payload_handle = best_reg.payload;
                            rsp_next.pending_count = 5'(held_reg - CW'(1));
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end
endmodule

@@ hw/rtl/filtered_fifo_mailbox.sv @@
// Top level of the filtered FIFO mailbox.
// Every transaction reads all SLOT_COUNT slots from the slot memory one per cycle,
// tracking the lowest free slot and the oldest matching message; an accepted
// transaction steps through the states PRIME, SCAN and DONE to reach its result;
// the next transaction is accepted once the result register can take a new result,
// at best in the cycle the result leaves, and never while a transaction is in progress.
// The maximum message size register resets to 4096 and is written by cfg_we/cfg_wdata.
`include "filtered_fifo_mailbox_defines.svh"
module filtered_fifo_mailbox
    import ffm_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    ffm_req_if.sink     req,
    ffm_rsp_if.source   rsp
);
    logic [15:0] max_size_reg;
    ctl_t        ctl;
    sts_t        sts;
    logic [SLOT_COUNT-1:0] valid_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= MAX_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            max_size_reg <= cfg_wdata;
        end
    end

    ffm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

    ffm_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (req.data),
        .max_message_size (max_size_reg),
        .ctl              (ctl),
        .sts              (sts),
        .rsp              (rsp.data),
        .valid_bits       (valid_bits)
    );

    `FFM_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, ctl.scan_step || ctl.finish, !req.ready)
    `FFM_ASSERT_NEXT(a_finish_valid, clk, rst_n, ctl.finish, rsp.valid)
    `FFM_ASSERT_NEXT(a_flush_clears, clk, rst_n, ctl.finish && u_dp.req_reg.cmd == CMD_FLUSH, valid_bits == '0)
endmodule
